// File: rtl/bgc_pkg.sv
// Shared types, gesture codes, register indexes and constants for the
// button gesture classifier. No dependencies.
package bgc_pkg;

    localparam int NUM_BUTTONS_DEF = 4;
    localparam int IDX_W           = 2;
    localparam int IDX_SPAN        = 1 << IDX_W;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    // fixed idle thresholds
    localparam logic [15:0] IDLE_T0 = 16'd10;
    localparam logic [15:0] IDLE_T1 = 16'd100;
    localparam logic [15:0] IDLE_T2 = 16'd200;

    localparam logic [15:0] PRESS_MAX = 16'hFFFF;
    localparam logic [7:0]  WIN_MAX   = 8'hFF;
    localparam logic [2:0]  CLICK_MAX = 3'd7;

    typedef enum logic [3:0] {
        G_RELEASE   = 4'd0,
        G_PRESS     = 4'd1,
        G_SINGLE    = 4'd2,
        G_DOUBLE    = 4'd3,
        G_TRIPLE    = 4'd4,
        G_LONG1     = 4'd5,
        G_LONG2     = 4'd6,
        G_HOLDON    = 4'd7,
        G_IDLE      = 4'd8,
        G_IDLE1     = 4'd9,
        G_IDLE2     = 4'd10,
        G_IDLE_LONG = 4'd11
    } t_gesture;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_DEBOUNCE    = 3'd0,
        REG_RELEASE_DEBOUNCE  = 3'd1,
        REG_SINGLE_PRESS_MAX  = 3'd2,
        REG_LONG_PRESS_FIRST  = 3'd3,
        REG_LONG_PRESS_SECOND = 3'd4,
        REG_HOLD_ON_TIME      = 3'd5,
        REG_CLICK_WINDOW      = 3'd6,
        REG_IDLE_LONG_TIME    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [IDX_W-1:0] button_index;
        logic             pressed;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0] button_id;
        t_gesture         gesture;
        logic [15:0]      press_time;
    } t_out;

    // queue entry between front and back
    typedef struct packed {
        logic [IDX_W-1:0] button_index;
        logic             pressed;
        logic             in_range;
    } t_item;

    typedef struct packed {
        logic [7:0]  press_debounce;
        logic [7:0]  release_debounce;
        logic [15:0] single_press_max;
        logic [15:0] long_press_first;
        logic [15:0] long_press_second;
        logic [15:0] hold_on_time;
        logic [7:0]  click_window;
        logic [15:0] idle_long_time;
    } t_cfg;

    typedef struct packed {
        t_gesture    gesture;
        logic [15:0] release_ticks;
        logic [15:0] press_ticks;
        logic [7:0]  window_ticks;
        logic [2:0]  click_count;
        logic        window_running;
    } t_bstate;

endpackage

// File: rtl/bgc_fifo.sv
// Two-entry queue of any packed type, push/full and pop/empty.
// Depends on bgc_pkg only through the type handed in.
module bgc_fifo #(
    parameter type t_data = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);

    t_data      r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push_ok, pop_ok;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = push_ok ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop_ok ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 2'd1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/bgc_cfg_regs.sv
// Configuration register file with a valid/ready write channel.
// Depends on bgc_pkg.
module bgc_cfg_regs
    import bgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg, n_cfg;

    // always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PRESS_DEBOUNCE:    n_cfg.press_debounce    = i_cfg_data[7:0];
                REG_RELEASE_DEBOUNCE:  n_cfg.release_debounce  = i_cfg_data[7:0];
                REG_SINGLE_PRESS_MAX:  n_cfg.single_press_max  = i_cfg_data;
                REG_LONG_PRESS_FIRST:  n_cfg.long_press_first  = i_cfg_data;
                REG_LONG_PRESS_SECOND: n_cfg.long_press_second = i_cfg_data;
                REG_HOLD_ON_TIME:      n_cfg.hold_on_time      = i_cfg_data;
                REG_CLICK_WINDOW:      n_cfg.click_window      = i_cfg_data[7:0];
                REG_IDLE_LONG_TIME:    n_cfg.idle_long_time    = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_debounce    <= 8'd5;
            r_cfg.release_debounce  <= 8'd5;
            r_cfg.single_press_max  <= 16'd20;
            r_cfg.long_press_first  <= 16'd90;
            r_cfg.long_press_second <= 16'd250;
            r_cfg.hold_on_time      <= 16'd600;
            r_cfg.click_window      <= 8'd40;
            r_cfg.idle_long_time    <= 16'd400;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: rtl/bgc_front.sv
// Front end: accepts tick samples, flags out-of-range buttons and
// queues them for the back end. Depends on bgc_pkg and bgc_fifo.
module bgc_front
    import bgc_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_in   i_in,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item item;

    always_comb begin
        item.button_index = i_in.button_index;
        item.pressed      = i_in.pressed;
        item.in_range     = (int'(i_in.button_index) < NUM_BUTTONS);
    end

    bgc_fifo #(
        .t_data (t_item)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (item),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty)
    );

endmodule

// File: rtl/bgc_back.sv
// Back end: per-button state table and gesture update, one sample a cycle
// while the result queue has room. Depends on bgc_pkg.
module bgc_back
    import bgc_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_out_full,
    output logic  o_take,
    output t_out  o_result
);

    // only indexes the input field can carry need state
    localparam int DEPTH = (NUM_BUTTONS < IDX_SPAN) ? NUM_BUTTONS : IDX_SPAN;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_bstate       r_state [DEPTH];
    t_bstate       cur, upd;
    t_gesture      g;
    logic [IW-1:0] sel;

    assign o_take = i_valid && !i_out_full;
    assign sel    = i_item.button_index[IW-1:0];
    assign cur    = r_state[sel];

    always_comb begin
        upd = cur;
        g   = cur.gesture;
        if (!i_item.pressed) begin
            if (cur.gesture >= G_PRESS && cur.gesture <= G_HOLDON) begin
                if (cur.release_ticks >= 16'(i_cfg.release_debounce)) g = G_RELEASE;
            end else begin
                case (cur.gesture)
                    G_RELEASE: if (cur.release_ticks >= IDLE_T0) g = G_IDLE;
                    G_IDLE:    if (cur.release_ticks >= IDLE_T1) g = G_IDLE1;
                    G_IDLE1:   if (cur.release_ticks >= IDLE_T2) g = G_IDLE2;
                    G_IDLE2: begin
                        if (cur.release_ticks >= i_cfg.idle_long_time) g = G_IDLE_LONG;
                    end
                    default: g = cur.gesture;
                endcase
            end
            if (cur.release_ticks < i_cfg.idle_long_time) begin
                upd.release_ticks = 16'(cur.release_ticks + 16'd1);
            end
            upd.press_ticks = 16'd0;
        end else begin
            if (cur.gesture == G_RELEASE) begin
                upd.release_ticks = 16'd0;
                if (cur.window_ticks >= i_cfg.press_debounce) begin
                    g = G_PRESS;
                    if (cur.click_count < CLICK_MAX) begin
                        upd.click_count = 3'(cur.click_count + 3'd1);
                    end
                end
                upd.window_running = 1'b1;
            end else if (cur.gesture >= G_IDLE && cur.gesture <= G_IDLE_LONG) begin
                g = G_RELEASE;
            end
            if (cur.press_ticks < PRESS_MAX) begin
                upd.press_ticks = 16'(cur.press_ticks + 16'd1);
            end
        end

        if (upd.window_running && upd.window_ticks < WIN_MAX) begin
            upd.window_ticks = 8'(upd.window_ticks + 8'd1);
        end
        // window end: classify the click burst and restart sampling
        if (upd.window_ticks >= i_cfg.click_window) begin
            if (upd.click_count == 3'd1 && upd.press_ticks <= i_cfg.single_press_max) begin
                g = G_SINGLE;
            end
            if (upd.click_count == 3'd2) g = G_DOUBLE;
            if (upd.click_count == 3'd3) g = G_TRIPLE;
            upd.click_count    = 3'd0;
            upd.window_ticks   = 8'd0;
            upd.window_running = 1'b0;
        end

        if (upd.press_ticks >= i_cfg.hold_on_time) begin
            g = G_HOLDON;
        end else if (upd.press_ticks >= i_cfg.long_press_second) begin
            g = G_LONG2;
        end else if (upd.press_ticks >= i_cfg.long_press_first) begin
            g = G_LONG1;
        end
        upd.gesture = g;

        o_result.button_id = i_item.button_index;
        if (i_item.in_range) begin
            o_result.gesture    = g;
            o_result.press_time = upd.press_ticks;
        end else begin
            o_result.gesture    = G_RELEASE;
            o_result.press_time = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_state[i] <= '0;
            end
        end else if (o_take && i_item.in_range) begin
            r_state[sel] <= upd;
        end
    end

endmodule

// File: rtl/button_gesture_classifier_core.sv
// Button gesture classifier core: per-button click, long-press and idle detection.
// A pushed sample waits in the front queue, is updated and its result registered
// into the result queue (o_empty low); one sample per cycle while it has room.
// Full back-pressure from the result queue stalls the front queue, then o_full.
// Reset (i_rst_n low, synchronous): queues emptied, all buttons released with
// zero counters, configuration registers back to their default values.
module button_gesture_classifier_core
    import bgc_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample input queue side
    input  logic                  i_push,
    input  t_in                   i_in,
    output logic                  o_full,
    // result queue side
    output logic                  o_empty,
    input  logic                  i_pop,
    output t_out                  o_out,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_item item;
    logic  item_empty;
    logic  item_take;
    logic  res_full;
    t_out  result;

    bgc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // front: accept and tag each sample transaction
    bgc_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_in    (i_in),
        .o_full  (o_full),
        .i_pop   (item_take),
        .o_item  (item),
        .o_empty (item_empty)
    );

    // back: state update, runs whenever a sample is queued and the result queue has room
    bgc_back #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (!item_empty),
        .i_item     (item),
        .i_out_full (res_full),
        .o_take     (item_take),
        .o_result   (result)
    );

    // result queue decouples the consumer from the state update
    bgc_fifo #(
        .t_data (t_out)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_take),
        .i_data  (result),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_out),
        .o_empty (o_empty)
    );

endmodule

// File: tb/sv/bgc_gesture_checker.sv
// Checker for the button gesture classifier: watches the sample, result and
// register channels, predicts each result and compares it. Depends on bgc_pkg.
`timescale 1ns / 1ps

module bgc_gesture_checker
    import bgc_pkg::*;
#(
    parameter int NUM_BTN = NUM_BUTTONS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  t_in                   i_in,
    input  logic                  i_pop,
    input  logic                  i_empty,
    input  t_out                  i_out,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_mismatch_count,
    output int                    o_checked_count
);

    t_cfg        regs;
    t_gesture    btn_gesture [NUM_BTN];
    logic [15:0] btn_release [NUM_BTN];
    logic [15:0] btn_press   [NUM_BTN];
    logic [7:0]  btn_window  [NUM_BTN];
    logic [2:0]  btn_clicks  [NUM_BTN];
    logic        btn_win_on  [NUM_BTN];

    t_out expected_gestures [$];
    t_out predicted;
    t_out oldest;
    int   mismatch_count = 0;
    int   checked_count  = 0;

    // Next gesture and press time of one button for one tick sample.
    task automatic classify_sample(input t_in smp, output t_out res);
        int unsigned b;
        logic [15:0] rel;
        t_gesture    prev;
        t_gesture    g;
        b = smp.button_index;
        res.button_id = smp.button_index;
        if (b >= NUM_BTN) begin
            res.gesture    = G_RELEASE;
            res.press_time = '0;
            return;
        end
        prev = btn_gesture[b];
        g    = prev;
        if (!smp.pressed) begin
            rel = btn_release[b];
            if (prev >= G_PRESS && prev <= G_HOLDON) begin
                if (rel >= regs.release_debounce) g = G_RELEASE;
            end else if (prev == G_RELEASE) begin
                if (rel >= IDLE_T0) g = G_IDLE;
            end else if (prev == G_IDLE) begin
                if (rel >= IDLE_T1) g = G_IDLE1;
            end else if (prev == G_IDLE1) begin
                if (rel >= IDLE_T2) g = G_IDLE2;
            end else if (prev == G_IDLE2) begin
                if (rel >= regs.idle_long_time) g = G_IDLE_LONG;
            end
            // release counter stops at the idle-long threshold (idle_long_time)
            if (rel < regs.idle_long_time) btn_release[b] = rel + 16'd1;
            btn_press[b] = '0;
        end else begin
            if (prev == G_RELEASE) begin
                btn_release[b] = '0;
                if (btn_window[b] >= regs.press_debounce) begin
                    g = G_PRESS;
                    if (btn_clicks[b] < CLICK_MAX) btn_clicks[b]++;
                end
                btn_win_on[b] = 1'b1;
            end else if (prev >= G_IDLE && prev <= G_IDLE_LONG) begin
                g = G_RELEASE;
            end
            if (btn_press[b] < PRESS_MAX) btn_press[b]++;
        end

        if (btn_win_on[b] && btn_window[b] < WIN_MAX) btn_window[b]++;
        // end of the click window: classify and restart
        if (btn_window[b] >= regs.click_window) begin
            if (btn_clicks[b] == 3'd1 && btn_press[b] <= regs.single_press_max) g = G_SINGLE;
            if (btn_clicks[b] == 3'd2) g = G_DOUBLE;
            if (btn_clicks[b] == 3'd3) g = G_TRIPLE;
            btn_clicks[b] = '0;
            btn_window[b] = '0;
            btn_win_on[b] = 1'b0;
        end

        if (btn_press[b] >= regs.hold_on_time) g = G_HOLDON;
        else if (btn_press[b] >= regs.long_press_second) g = G_LONG2;
        else if (btn_press[b] >= regs.long_press_first) g = G_LONG1;

        btn_gesture[b] = g;
        res.gesture    = g;
        res.press_time = btn_press[b];
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs = '{press_debounce: 8'd5, release_debounce: 8'd5,
                     single_press_max: 16'd20, long_press_first: 16'd90,
                     long_press_second: 16'd250, hold_on_time: 16'd600,
                     click_window: 8'd40, idle_long_time: 16'd400};
            for (int i = 0; i < NUM_BTN; i++) begin
                btn_gesture[i] = G_RELEASE;
                btn_release[i] = '0;
                btn_press[i]   = '0;
                btn_window[i]  = '0;
                btn_clicks[i]  = '0;
                btn_win_on[i]  = 1'b0;
            end
            expected_gestures.delete();
        end else begin
            // results leave before this edge's sample is predicted
            if (i_pop && !i_empty) begin
                if (expected_gestures.size() == 0) begin
                    mismatch_count++;
                    $error("result with no sample outstanding: button_id %0d gesture %0d",
                           i_out.button_id, i_out.gesture);
                end else begin
                    oldest = expected_gestures.pop_front();
                    checked_count++;
                    if (i_out.button_id !== oldest.button_id) begin
                        mismatch_count++;
                        $error("button_id: expected %0d, actual %0d",
                               oldest.button_id, i_out.button_id);
                    end
                    if (i_out.gesture !== oldest.gesture) begin
                        mismatch_count++;
                        $error("gesture: expected %0d, actual %0d",
                               oldest.gesture, i_out.gesture);
                    end
                    if (i_out.press_time !== oldest.press_time) begin
                        mismatch_count++;
                        $error("press_time: expected %0d, actual %0d",
                               oldest.press_time, i_out.press_time);
                    end
                end
            end
            if (i_push && !i_full) begin
                classify_sample(i_in, predicted);
                expected_gestures.push_back(predicted);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_PRESS_DEBOUNCE:    regs.press_debounce    = i_cfg_data[7:0];
                    REG_RELEASE_DEBOUNCE:  regs.release_debounce  = i_cfg_data[7:0];
                    REG_SINGLE_PRESS_MAX:  regs.single_press_max  = i_cfg_data;
                    REG_LONG_PRESS_FIRST:  regs.long_press_first  = i_cfg_data;
                    REG_LONG_PRESS_SECOND: regs.long_press_second = i_cfg_data;
                    REG_HOLD_ON_TIME:      regs.hold_on_time      = i_cfg_data;
                    REG_CLICK_WINDOW:      regs.click_window      = i_cfg_data[7:0];
                    REG_IDLE_LONG_TIME:    regs.idle_long_time    = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending        <= expected_gestures.size();
        o_mismatch_count <= mismatch_count;
        o_checked_count  <= checked_count;
    end

endmodule

// File: tb/sv/tb_button_gesture_classifier_core.sv
// Top of the button gesture classifier testbench: clock, reset, sample and
// register stimulus, result draining and the verdict. Depends on bgc_pkg,
// bgc_gesture_checker and button_gesture_classifier_core.
`timescale 1ns / 1ps

module tb_button_gesture_classifier_core;
    import bgc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transaction at all
    localparam int SETTLE_CYCLES  = 6;      // margin after the last result is popped
    localparam int HOLD_TICKS     = 60;     // long enough to pass hold-on

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    t_in                   smp       = '0;
    logic                  full;
    logic                  empty;
    logic                  pop       = 1'b0;
    t_out                  res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int pending;
    int mismatch_count;
    int checked_count;

    // stimulus bookkeeping
    t_cfg cur_cfg;             // last register set written, shapes run lengths
    bit   gaps_on = 1'b1;      // random idling on both channels
    int   pop_stall = 0;
    int   quiet_cycles = 0;
    int   samples_sent = 0;
    int   focus_btn = 0;
    logic btn_level [4];       // level each button's script is playing
    int   btn_run   [4];       // ticks left at that level

    button_gesture_classifier_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .i_in        (smp),
        .o_full      (full),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bgc_gesture_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_in             (smp),
        .i_pop            (pop),
        .i_empty          (empty),
        .i_out            (res),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_pending        (pending),
        .o_mismatch_count (mismatch_count),
        .o_checked_count  (checked_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle gap: mostly none, often a few cycles, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // How long a button stays at a level: lengths cluster around the
    // debounce, click window, long-press and idle thresholds in force.
    function automatic int pick_run(logic lvl);
        int r;
        int lim;
        r = $urandom_range(0, 99);
        if (lvl) begin
            lim = int'(cur_cfg.press_debounce) + 4;
            if (lim > 40) lim = 40;
            if (r < 55) return $urandom_range(1, lim);
            lim = int'(cur_cfg.long_press_first) + 8;
            if (lim > 80) lim = 80;
            if (r < 85) return $urandom_range(1, lim);
            lim = int'(cur_cfg.hold_on_time) + 8;
            if (lim > 160) lim = 160;
            return $urandom_range(1, lim);
        end
        lim = int'(cur_cfg.release_debounce) + 4;
        if (lim > 30) lim = 30;
        if (r < 50) return $urandom_range(1, lim);
        lim = int'(cur_cfg.click_window) + 8;
        if (lim > 60) lim = 60;
        if (r < 85) return $urandom_range(1, lim);
        lim = int'(cur_cfg.idle_long_time) + 20;
        if (lim > 280) lim = 280;
        return $urandom_range(1, lim);
    endfunction

    // Thresholds small enough that clicks, long presses and all idle levels
    // show up within a few hundred samples.
    function automatic t_cfg small_cfg();
        t_cfg c;
        c.press_debounce    = 8'($urandom_range(0, 4));
        c.release_debounce  = 8'($urandom_range(0, 4));
        c.single_press_max  = 16'($urandom_range(1, 12));
        c.long_press_first  = 16'($urandom_range(15, 40));
        c.long_press_second = c.long_press_first + 16'($urandom_range(5, 30));
        c.hold_on_time      = c.long_press_second + 16'($urandom_range(5, 40));
        c.click_window      = 8'($urandom_range(6, 24));
        c.idle_long_time    = 16'($urandom_range(205, 240));
        return c;
    endfunction

    function automatic t_cfg wide_cfg();
        t_cfg c;
        c.press_debounce    = 8'($urandom);
        c.release_debounce  = 8'($urandom);
        c.single_press_max  = 16'($urandom);
        c.long_press_first  = 16'($urandom);
        c.long_press_second = 16'($urandom);
        c.hold_on_time      = 16'($urandom);
        c.click_window      = 8'($urandom_range(1, 255));
        c.idle_long_time    = 16'($urandom);
        return c;
    endfunction

    // Result side: pop stays high except for random stalls after a transaction.
    always @(posedge clk) begin
        if (!rst_n) begin
            pop_stall = 0;
            pop <= 1'b0;
        end else begin
            if (pop && !empty) pop_stall = gaps_on ? pick_gap() : 0;
            if (pop_stall > 0) begin
                pop_stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: any transaction on any channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_button_gesture_classifier_core: done, errors");
            $finish;
        end
    end

    // One sample transaction; push stays high into the next call when no
    // gap is drawn so back-to-back samples go at full rate.
    task automatic send_sample(input logic [IDX_W-1:0] btn, input logic lvl);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        smp  <= '{button_index: btn, pressed: lvl};
        do @(posedge clk); while (full);
        samples_sent++;
    endtask

    // Stop sending and wait until every predicted result has been popped.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Writes the whole register set; only called with the block idle.
    task automatic apply_cfg(input t_cfg c);
        cur_cfg = c;
        write_reg(REG_PRESS_DEBOUNCE,    {8'h00, c.press_debounce});
        write_reg(REG_RELEASE_DEBOUNCE,  {8'h00, c.release_debounce});
        write_reg(REG_SINGLE_PRESS_MAX,  c.single_press_max);
        write_reg(REG_LONG_PRESS_FIRST,  c.long_press_first);
        write_reg(REG_LONG_PRESS_SECOND, c.long_press_second);
        write_reg(REG_HOLD_ON_TIME,      c.hold_on_time);
        write_reg(REG_CLICK_WINDOW,      {8'h00, c.click_window});
        write_reg(REG_IDLE_LONG_TIME,    c.idle_long_time);
    endtask

    // Interleaved press/release scripts on all four buttons, one button in
    // focus so its long idle stretches get through; a few glitch samples.
    task automatic run_gestures(input int n_items);
        int btn;
        focus_btn = $urandom_range(0, 3);
        for (int k = 0; k < n_items; k++) begin
            // alternate stretches with and without idling
            if (k % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 8) begin
                send_sample(IDX_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                continue;
            end
            btn = ($urandom_range(0, 99) < 70) ? focus_btn : $urandom_range(0, 3);
            if (btn_run[btn] == 0) begin
                btn_level[btn] = ~btn_level[btn];
                btn_run[btn]   = pick_run(btn_level[btn]);
            end
            btn_run[btn]--;
            send_sample(IDX_W'(btn), btn_level[btn]);
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < 4; i++) begin
            btn_level[i] = 1'b0;
            btn_run[i]   = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: no debounce and a maximal window so button 1 clicks
        // until the click count saturates; button 0 idles meanwhile, with
        // a low idle ceiling, then a press pulls it back from idle.
        apply_cfg('{press_debounce: 8'd0, release_debounce: 8'd0,
                    single_press_max: 16'hFFFF, long_press_first: 16'hFFFF,
                    long_press_second: 16'hFFFF, hold_on_time: 16'hFFFF,
                    click_window: 8'd255, idle_long_time: 16'd12});
        for (int i = 0; i < 15; i++) begin
            send_sample(2'd1, ~i[0]);
            if (i < 12) send_sample(2'd0, 1'b0);
        end
        send_sample(2'd0, 1'b1);
        settle();

        // All-zero registers: the window ends every tick and every level
        // threshold is met at once.
        apply_cfg('0);
        send_sample(2'd2, 1'b1);
        send_sample(2'd3, 1'b0);
        send_sample(2'd2, 1'b0);
        send_sample(2'd3, 1'b1);
        settle();

        // One long hold on button 3 at full rate, through both long levels
        // and into hold-on, then a release.
        apply_cfg('{press_debounce: 8'd0, release_debounce: 8'd0,
                    single_press_max: 16'd20, long_press_first: 16'd20,
                    long_press_second: 16'd35, hold_on_time: 16'd50,
                    click_window: 8'd255, idle_long_time: 16'd400});
        gaps_on = 1'b0;
        repeat (HOLD_TICKS) send_sample(2'd3, 1'b1);
        send_sample(2'd3, 1'b0);
        gaps_on = 1'b1;
        settle();

        // Random gesture traffic under a series of register sets.
        apply_cfg('{press_debounce: 8'd5, release_debounce: 8'd5,
                    single_press_max: 16'd20, long_press_first: 16'd90,
                    long_press_second: 16'd250, hold_on_time: 16'd600,
                    click_window: 8'd40, idle_long_time: 16'd400});
        run_gestures(220);
        settle();
        apply_cfg(small_cfg());
        run_gestures(120);
        settle();                       // sender holds off until all results are in
        run_gestures(130);
        settle();
        apply_cfg(small_cfg());
        run_gestures(250);
        settle();
        apply_cfg('1);
        run_gestures(130);
        settle();
        apply_cfg(wide_cfg());
        run_gestures(130);
        settle();
        apply_cfg(small_cfg());
        run_gestures(250);
        settle();

        $display("tb_button_gesture_classifier_core: %0d samples sent, %0d results checked",
                 samples_sent, checked_count);
        $display("covered: click saturation, idle levels, zero/max/reset/random registers, %0d-tick hold",
                 HOLD_TICKS);
        if (mismatch_count == 0 && pending == 0) begin
            $display("tb_button_gesture_classifier_core: done, clean");
        end else begin
            $display("tb_button_gesture_classifier_core: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/bgc_pkg.sv
rtl/bgc_fifo.sv
rtl/bgc_cfg_regs.sv
rtl/bgc_front.sv
rtl/bgc_back.sv
rtl/button_gesture_classifier_core.sv
tb/sv/bgc_gesture_checker.sv
tb/sv/tb_button_gesture_classifier_core.sv
